// File: rtl/fir_filter_q15_saturating_assert.svh
// Assertion macros for the saturating Q15 FIR filter.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef FIR_FILTER_Q15_SATURATING_ASSERT_SVH
`define FIR_FILTER_Q15_SATURATING_ASSERT_SVH
`ifndef SYNTHESIS
`define FQS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fir_filter_q15_saturating: same-cycle check failed");
`define FQS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fir_filter_q15_saturating: next-cycle check failed");
`else
`define FQS_ASSERT_IMP(lbl, ante, cons)
`define FQS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/fir_q15_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fir_q15_pkg;

	localparam int TAPS_DEF  = 63;
	localparam int DATA_W    = 16;
	localparam int TAP_IDX_W = 6;
	// wide enough to compare a tap index against any tap count up to 256
	localparam int TAP_CMP_W = 9;
	localparam int PROD_W    = 2 * DATA_W;

	localparam logic signed [31:0] ROUND_BIAS = 32'sd16384;
	localparam logic signed [31:0] SAT_HI     = 32'sh3FFF_FFFF;
	localparam logic signed [31:0] SAT_LO     = 32'shC000_0000;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_FILTER = 1'b1;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage
`default_nettype wire

// File: rtl/fir_q15_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module fir_q15_ram #(
	parameter int DEPTH = fir_q15_pkg::TAPS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            we,
	input  wire logic [AW-1:0]                   waddr,
	input  wire logic [fir_q15_pkg::DATA_W-1:0]  wdata,
	input  wire logic [AW-1:0]                   raddr,
	output logic      [fir_q15_pkg::DATA_W-1:0]  rdata
);
	import fir_q15_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/fir_q15_mac.sv
`timescale 1ns / 1ps
`default_nettype none
module fir_q15_mac #(
	parameter int ACC_W = 34
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire fir_q15_pkg::mac_ctl_t                 ctl,
	input  wire logic signed [fir_q15_pkg::DATA_W-1:0] coef,
	input  wire logic signed [fir_q15_pkg::DATA_W-1:0] samp,
	output logic                                       done,
	output logic signed [fir_q15_pkg::DATA_W-1:0]      result
);
	import fir_q15_pkg::*;

	localparam logic signed [ACC_W-1:0] BIAS_A = ACC_W'(ROUND_BIAS);
	localparam logic signed [ACC_W-1:0] HI_A   = ACC_W'(SAT_HI);
	localparam logic signed [ACC_W-1:0] LO_A   = ACC_W'(SAT_LO);

	mac_ctl_t                 ctl_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_base;
	logic signed [ACC_W-1:0]  sat;
	logic                     done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl;
			done_q <= ctl_s2.vld && ctl_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef * samp;
	end

	// restart from the rounding bias on the first tap
	assign acc_base = ctl_s2.first ? BIAS_A : acc_q;

	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			acc_q <= acc_base + ACC_W'(prod_s2);
		end
	end

	always_comb begin
		priority if (acc_q > HI_A) begin
			sat = HI_A;
		end else if (acc_q < LO_A) begin
			sat = LO_A;
		end else begin
			sat = acc_q;
		end
	end

	// clamped sum fits 31 bits; bits 30..15 are the arithmetic shift by 15
	assign result = sat[30:15];
	assign done   = done_q;

endmodule
`default_nettype wire

// File: rtl/fir_filter_q15_saturating.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake               Payload
// input     in_valid / in_stall     command, tap_index, coef_value, sample_in
// output    out_valid / out_stall   sample_out
//
// A load item keeps the block in IDLE; a tap index at or beyond TAPS is dropped.
// A filter item goes through RUN and WAIT to FINISH before the block accepts again:
// one shared 16x16 multiply-accumulate unit walks all taps, one tap per cycle.
// After reset both stores read as zero: coefficients carry a valid bit each, and
// the delay line keeps a fill count, so no clearing pass is needed.
// A finished result waits in the output register; the block accepts the next item
// while it is stalled and only holds its own result back if that one is still there.
module fir_filter_q15_saturating #(
	parameter int TAPS = fir_q15_pkg::TAPS_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	output logic                                          in_stall,
	input  wire logic                                     command,
	input  wire logic [fir_q15_pkg::TAP_IDX_W-1:0]        tap_index,
	input  wire logic signed [fir_q15_pkg::DATA_W-1:0]    coef_value,
	input  wire logic signed [fir_q15_pkg::DATA_W-1:0]    sample_in,
	output logic                                          out_valid,
	input  wire logic                                     out_stall,
	output logic signed [fir_q15_pkg::DATA_W-1:0]         sample_out
);
	import fir_q15_pkg::*;
	`include "fir_filter_q15_saturating_assert.svh"

	localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int FW    = $clog2(TAPS + 1);
	localparam int ACC_W = PROD_W + 2 + $clog2(TAPS + 1);

	localparam logic [AW-1:0]        LAST_IDX = AW'(TAPS - 1);
	localparam logic [FW-1:0]        FILL_MAX = FW'(TAPS);
	localparam logic [TAP_CMP_W-1:0] TAPS_CMP = TAP_CMP_W'(TAPS);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_RUN    = 4'b0010,
		ST_WAIT   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       idx_q;      // tap position being read
	logic [AW-1:0]       ptr_q;      // delay buffer address of that position
	logic [AW-1:0]       head_q;     // buffer address of the newest sample
	logic [AW-1:0]       head_nxt;
	logic [FW-1:0]       fill_q;     // samples seen so far, saturates at TAPS
	logic [TAPS-1:0]     coef_vld_q;

	logic                 accept;
	logic                 ld_acc;
	logic                 smp_acc;
	logic [TAP_CMP_W-1:0] tap_ext;
	logic                 tap_ok;
	logic [AW-1:0]        tap_addr;

	mac_ctl_t            ctl_s1;
	logic                cok_s1;
	logic                dok_s1;
	logic [DATA_W-1:0]   coef_rd;
	logic [DATA_W-1:0]   dly_rd;
	logic signed [DATA_W-1:0] coef_op;
	logic signed [DATA_W-1:0] samp_op;

	logic                      mac_done;
	logic signed [DATA_W-1:0]  mac_res;
	logic                      out_valid_q;
	logic signed [DATA_W-1:0]  sample_out_q;
	logic                      out_free;

	// --- input handshake: one item at a time, busy outside IDLE
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign ld_acc   = accept && (command == CMD_LOAD);
	assign smp_acc  = accept && (command == CMD_FILTER);

	assign tap_ext  = TAP_CMP_W'(tap_index);
	assign tap_ok   = (tap_ext < TAPS_CMP);
	assign tap_addr = tap_ext[AW-1:0];

	// the delay line is a circular buffer; a new sample moves the head back one
	assign head_nxt = (head_q == '0) ? LAST_IDX : head_q - AW'(1);

	fir_q15_ram #(.DEPTH(TAPS), .AW(AW)) u_coef_ram (
		.clk   (clk),
		.we    (ld_acc && tap_ok),
		.waddr (tap_addr),
		.wdata (coef_value),
		.raddr (idx_q),
		.rdata (coef_rd)
	);

	fir_q15_ram #(.DEPTH(TAPS), .AW(AW)) u_dly_ram (
		.clk   (clk),
		.we    (smp_acc),
		.waddr (head_nxt),
		.wdata (sample_in),
		.raddr (ptr_q),
		.rdata (dly_rd)
	);

	// --- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			ptr_q      <= '0;
			head_q     <= '0;
			fill_q     <= '0;
			coef_vld_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ld_acc && tap_ok) begin
						coef_vld_q[tap_addr] <= 1'b1;
					end
					if (smp_acc) begin
						head_q  <= head_nxt;
						ptr_q   <= head_nxt;
						idx_q   <= '0;
						if (fill_q != FILL_MAX) begin
							fill_q <= fill_q + FW'(1);
						end
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// advance one tap per cycle, wrap the buffer address
					ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + AW'(1);
					if (idx_q == LAST_IDX) begin
						state_q <= ST_WAIT;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_WAIT: begin
					if (mac_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// --- read stage: control travels alongside the registered RAM data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			cok_s1 <= 1'b0;
			dok_s1 <= 1'b0;
		end else begin
			ctl_s1.vld   <= (state_q == ST_RUN);
			ctl_s1.first <= (idx_q == '0);
			ctl_s1.last  <= (idx_q == LAST_IDX);
			cok_s1       <= coef_vld_q[idx_q];
			dok_s1       <= (FW'(idx_q) < fill_q);
		end
	end

	// never-written entries read as zero
	assign coef_op = cok_s1 ? coef_rd : '0;
	assign samp_op = dok_s1 ? dly_rd : '0;

	fir_q15_mac #(.ACC_W(ACC_W)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s1),
		.coef   (coef_op),
		.samp   (samp_op),
		.done   (mac_done),
		.result (mac_res)
	);

	// --- output register: load when empty or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			priority if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FINISH) && out_free) begin
			sample_out_q <= mac_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// --- checks
	`FQS_ASSERT_IMP(a_done_in_wait, mac_done, state_q == ST_WAIT)
	`FQS_ASSERT_NXT(a_sample_starts_run, smp_acc, (state_q == ST_RUN) && (idx_q == '0))
	`FQS_ASSERT_IMP(a_out_from_finish, $rose(out_valid_q), $past(state_q) == ST_FINISH)

endmodule
`default_nettype wire

// File: test/fir_filter_q15_saturating_checker.sv
`timescale 1ns / 1ps
module fir_filter_q15_saturating_checker #(
	parameter int TAPS = fir_q15_pkg::TAPS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	input  logic                                      in_stall,
	input  logic                                      command,
	input  logic [fir_q15_pkg::TAP_IDX_W-1:0]         tap_index,
	input  logic signed [fir_q15_pkg::DATA_W-1:0]     coef_value,
	input  logic signed [fir_q15_pkg::DATA_W-1:0]     sample_in,
	input  logic                                      out_valid,
	input  logic                                      out_stall,
	input  logic signed [fir_q15_pkg::DATA_W-1:0]     sample_out,
	output int                                        mismatches,
	output int                                        outputs_due
);
	import fir_q15_pkg::*;

	logic signed [DATA_W-1:0] coefs [TAPS];
	logic signed [DATA_W-1:0] history [TAPS];
	logic signed [DATA_W-1:0] filtered_due [$];
	int errors;

	// Insert the sample, sum all taps with rounding, advance the history, then clamp.
	function automatic logic signed [DATA_W-1:0] fir_output(input logic signed [DATA_W-1:0] smp);
		longint acc;
		longint scaled;
		history[0] = smp;
		acc = longint'(ROUND_BIAS);
		for (int i = 0; i < TAPS; i++)
			acc += longint'(coefs[i]) * longint'(history[i]);
		for (int i = TAPS - 1; i > 0; i--)
			history[i] = history[i - 1];
		if (acc > longint'(SAT_HI))
			acc = longint'(SAT_HI);
		else if (acc < longint'(SAT_LO))
			acc = longint'(SAT_LO);
		scaled = acc >>> 15;
		return scaled[DATA_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				coefs[i]   = '0;
				history[i] = '0;
			end
			filtered_due.delete();
			errors = 0;
			mismatches  <= 0;
			outputs_due <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (filtered_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected output item: sample_out %0d", sample_out);
				end else begin
					if (sample_out !== filtered_due[0]) begin
						errors++;
						if (errors <= 10)
							$display("sample_out mismatch: expected %0d, got %0d",
								filtered_due[0], sample_out);
					end
					void'(filtered_due.pop_front());
				end
			end
			if (in_valid && !in_stall) begin
				if (command == CMD_FILTER)
					filtered_due.push_back(fir_output(sample_in));
				else if (int'(tap_index) < TAPS)
					coefs[tap_index] = coef_value;
			end
			mismatches  <= errors;
			outputs_due <= filtered_due.size();
		end
	end
endmodule

// File: test/tb_fir_filter_q15_saturating.sv
`timescale 1ns / 1ps
module tb_fir_filter_q15_saturating;
	import fir_q15_pkg::*;

	localparam int TAPS         = TAPS_DEF;
	localparam int RANDOM_ITEMS = 750;
	// the last stretch of random items runs with no gaps and no output stalls
	localparam int CALM_ITEMS   = 100;
	localparam int DRAIN_CYCLES = TAPS + 20;
	// slowest run: every item a filter, each with the longest gap and the longest stall
	localparam int LIMIT_CYCLES = 6 * (RANDOM_ITEMS + 30) * (TAPS + 5 + 32);

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic                      command;
	logic [TAP_IDX_W-1:0]      tap_index;
	logic signed [DATA_W-1:0]  coef_value;
	logic signed [DATA_W-1:0]  sample_in;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [DATA_W-1:0]  sample_out;

	int mismatches;
	int outputs_due;
	int cycles = 0;

	// idle controls: send_idle enables sender gaps for a stretch, stall_on the same for
	// the receiver; calm_tail switches both off for the final part of the run
	logic calm_tail;
	bit   send_idle;
	logic stall_on;
	int   stall_left;
	int   mode_left;

	fir_filter_q15_saturating #(.TAPS(TAPS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.tap_index  (tap_index),
		.coef_value (coef_value),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

	fir_filter_q15_saturating_checker #(.TAPS(TAPS)) mon (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.tap_index   (tap_index),
		.coef_value  (coef_value),
		.sample_in   (sample_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample_out  (sample_out),
		.mismatches  (mismatches),
		.outputs_due (outputs_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: give up on a hung or starved block.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Output stall generator: random stall bursts, switched on and off in random
	// stretches so that long runs with no stall occur as well.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
			mode_left  <= 0;
			stall_on   <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_on  <= $urandom_range(0, 2) != 0;
				mode_left <= $urandom_range(100, 600);
			end else begin
				mode_left <= mode_left - 1;
			end
			if (stall_left > 0) begin
				out_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (!calm_tail && stall_on && $urandom_range(0, 5) == 0) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 15);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Pick a gap before the next item: mostly none, sometimes an idle burst.
	function automatic int pick_gap();
		if (calm_tail || !send_idle)
			return 0;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(1, 16);
		return 0;
	endfunction

	// Favor the extremes and values near zero; otherwise any 16-bit pattern.
	function automatic logic signed [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return DATA_W'($urandom_range(0, 31)) - DATA_W'(16);
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// Drive one item, hold it until accepted, return right after the accepting edge.
	task automatic send_item(input logic cmd, input logic [TAP_IDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] cf, input logic signed [DATA_W-1:0] smp,
			input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		tap_index  <= idx;
		coef_value <= cf;
		sample_in  <= smp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	initial begin
		logic is_load;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		command    <= CMD_LOAD;
		tap_index  <= '0;
		coef_value <= '0;
		sample_in  <= '0;
		calm_tail  <= 1'b0;
		send_idle  = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		// Filter on an empty coefficient store: the result is zero.
		send_item(CMD_FILTER, 6'd5, 16'sh1234, 16'sh7FFF, pick_gap());
		// Load both ends of the store; an index past the last tap must be dropped.
		send_item(CMD_LOAD, 6'd0, 16'sh8000, 16'sh7FFF, pick_gap());
		send_item(CMD_LOAD, TAP_IDX_W'(TAPS - 1), 16'sh7FFF, 16'sh8000, pick_gap());
		send_item(CMD_LOAD, 6'd63, 16'sh3039, 16'sh0000, pick_gap());
		send_item(CMD_LOAD, 6'd1, 16'sh8000, 16'shFFFF, pick_gap());
		// Two full-scale negative samples through two full-scale negative taps:
		// the sum reaches 2^31 and must clamp at the positive bound.
		send_item(CMD_FILTER, 6'd63, 16'shFFFF, 16'sh8000, pick_gap());
		send_item(CMD_FILTER, 6'd0, 16'sh7FFF, 16'sh8000, pick_gap());
		// Flip the taps to full-scale positive: the sum clamps at the negative bound.
		send_item(CMD_LOAD, 6'd0, 16'sh7FFF, 16'sh0000, pick_gap());
		send_item(CMD_LOAD, 6'd1, 16'sh7FFF, 16'sh0000, pick_gap());
		send_item(CMD_FILTER, 6'd62, 16'sh8000, 16'sh8000, pick_gap());
		send_item(CMD_FILTER, 6'd21, 16'sh5555, 16'sh8000, pick_gap());
		// Mixed signs and small values; ignored fields carry junk.
		send_item(CMD_LOAD, 6'd2, 16'shFFFF, 16'shAAAA, pick_gap());
		send_item(CMD_FILTER, 6'd42, 16'shAAAA, 16'sh0001, pick_gap());
		send_item(CMD_FILTER, 6'd63, 16'sh0000, 16'shFFFF, pick_gap());
		send_item(CMD_FILTER, 6'd0, 16'sh7FFF, 16'sh0000, pick_gap());
		send_item(CMD_LOAD, 6'd0, 16'sh0000, 16'sh7FFF, pick_gap());
		send_item(CMD_FILTER, 6'd1, 16'sh0001, 16'sh4000, pick_gap());

		// Random part: one load in four, the rest filter items. Extreme values are
		// frequent so that saturation shows up, and the history fills to the last tap.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				send_idle = $urandom_range(0, 2) != 0;
			if (n >= RANDOM_ITEMS - CALM_ITEMS)
				calm_tail <= 1'b1;
			is_load = $urandom_range(0, 3) == 0;
			send_item(is_load ? CMD_LOAD : CMD_FILTER, TAP_IDX_W'($urandom_range(0, 63)),
				pick_word(), pick_word(), pick_gap());
		end
		in_valid <= 1'b0;

		// Drain: wait for every expected output, then let the pipeline settle.
		while (outputs_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+rtl
rtl/fir_q15_pkg.sv
rtl/fir_q15_ram.sv
rtl/fir_q15_mac.sv
rtl/fir_filter_q15_saturating.sv
test/fir_filter_q15_saturating_checker.sv
test/tb_fir_filter_q15_saturating.sv
